### rtl/assert_macros.svh
// Assertion helpers used by the top-level core.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check on every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/sptrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sptrm_pkg;

  localparam int unsigned CMD_W     = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned STS_W     = 2;
  localparam int unsigned LOG_W     = 4;
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 48;

  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_BAD_RANGE = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_APPEND,
    ST_QRY_A,
    ST_QRY_B,
    ST_QRY_C,
    ST_FINISH
  } sptrm_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic decode;
    logic app_step;
    logic qry_rd_a;
    logic qry_rd_b;
    logic qry_done;
    logic out_load;
  } sptrm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic app_go;
    logic qry_go;
    logic app_more;
    logic out_full;
  } sptrm_stat_t;

  // Index of the highest set bit; zero for a zero input
  function automatic logic [LOG_W-1:0] floor_log2(input logic [POS_W-1:0] len);
    logic [LOG_W-1:0] k;
    k = '0;
    for (int i = 0; i < int'(POS_W); i++) begin
      if (len[i]) k = LOG_W'(i);
    end
    return k;
  endfunction

  function automatic logic signed [VAL_W-1:0] max32(input logic signed [VAL_W-1:0] a,
                                                    input logic signed [VAL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### rtl/sptrm_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sptrm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/sptrm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sptrm_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  output logic                        s_tready_o,
  input  wire sptrm_pkg::sptrm_stat_t stat_i,
  output sptrm_pkg::sptrm_cmd_t       cmd_o
);

  import sptrm_pkg::*;

  sptrm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (stat_i.app_go) state_d = ST_APPEND;
        else if (stat_i.qry_go) state_d = ST_QRY_A;
        else state_d = ST_FINISH;
      end
      ST_APPEND: begin
        if (!stat_i.app_more) state_d = ST_FINISH;
      end
      ST_QRY_A: state_d = ST_QRY_B;
      ST_QRY_B: state_d = ST_QRY_C;
      ST_QRY_C: state_d = ST_FINISH;
      ST_FINISH: begin
        if (!stat_i.out_full) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.capture = s_tvalid_i;
      end
      ST_DECODE: cmd_o.decode   = 1'b1;
      ST_APPEND: cmd_o.app_step = 1'b1;
      ST_QRY_A:  cmd_o.qry_rd_a = 1'b1;
      ST_QRY_B:  cmd_o.qry_rd_b = 1'b1;
      ST_QRY_C:  cmd_o.qry_done = 1'b1;
      ST_FINISH: cmd_o.out_load = !stat_i.out_full;
      default: begin
        s_tready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/sptrm_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sptrm_dp #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic [sptrm_pkg::S_TDATA_W-1:0]      s_tdata_i,
  input  wire logic [sptrm_pkg::CMD_W-1:0]          s_tuser_i,
  input  wire logic                                 m_tready_i,
  output logic                                      m_tvalid_o,
  output logic      [sptrm_pkg::M_TDATA_W-1:0]      m_tdata_o,
  output logic      [sptrm_pkg::STS_W-1:0]          m_tuser_o,
  input  wire sptrm_pkg::sptrm_cmd_t                cmd_i,
  output sptrm_pkg::sptrm_stat_t                    stat_o
);

  import sptrm_pkg::*;

  localparam int unsigned PW    = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW    = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned LVW   = $clog2(LEVELS);
  localparam int unsigned AW    = LVW + PW;
  localparam int unsigned DEPTH = LEVELS << PW;
  localparam int unsigned CMPW  = (CW > POS_W) ? CW : POS_W;

  // Item registers
  logic [CMD_W-1:0]        cmd_q;
  logic signed [VAL_W-1:0] value_q;
  logic [POS_W-1:0]        left_q, right_q;

  logic [CW-1:0]           count_q;
  logic [LVW-1:0]          lvl_q;
  logic [LVW-1:0]          qlvl_q;
  logic signed [VAL_W-1:0] run_q;
  logic signed [VAL_W-1:0] hold_q;
  logic signed [VAL_W-1:0] res_q;
  logic [STS_W-1:0]        sts_q;

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] out_max_q;
  logic [STS_W-1:0]        out_sts_q;
  logic [POS_W-1:0]        out_count_q;

  logic [CW-1:0]           pos_new;
  logic                    tbl_full;
  logic                    range_bad;
  logic [POS_W-1:0]        qlen;
  logic [LOG_W-1:0]        qlog;
  logic [LVW-1:0]          qlvl_d;
  logic [LVW:0]            next_lvl;
  logic                    app_more;
  logic [CW-1:0]           wr_idx;
  logic [CW-1:0]           rd_idx;
  logic [POS_W-1:0]        qb_idx;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic signed [VAL_W-1:0] ram_wdata;
  logic [VAL_W-1:0]        ram_rdata;
  logic signed [VAL_W-1:0] rdata_s;

  assign rdata_s   = $signed(ram_rdata);
  assign pos_new   = count_q + CW'(1);
  assign tbl_full  = (count_q == CW'(MAX_ELEMENTS));
  assign range_bad = (left_q == '0) || (right_q < left_q) ||
                     (CMPW'(right_q) > CMPW'(count_q));

  assign qlen = right_q - left_q + POS_W'(1);
  assign qlog = floor_log2(qlen);

  always_comb begin
    if (int'(qlog) > int'(LEVELS) - 1) qlvl_d = LVW'(LEVELS - 1);
    else qlvl_d = LVW'(qlog);
  end

  // Window at level lvl_q ending at the new position; the next level reads its left half
  assign next_lvl = {1'b0, lvl_q} + (LVW + 1)'(1);
  assign app_more = (int'(next_lvl) < int'(LEVELS)) && ((pos_new >> next_lvl) != '0);
  assign wr_idx   = pos_new - (CW'(1) << lvl_q);
  assign rd_idx   = pos_new - (CW'(1) << next_lvl);
  assign qb_idx   = right_q - (POS_W'(1) << qlvl_q);

  always_comb begin
    if (lvl_q == '0) ram_wdata = value_q;
    else ram_wdata = max32(rdata_s, run_q);
  end

  assign ram_we    = cmd_i.app_step;
  assign ram_waddr = {lvl_q, PW'(wr_idx)};
  assign ram_re    = (cmd_i.app_step && app_more) || cmd_i.qry_rd_a || cmd_i.qry_rd_b;

  always_comb begin
    if (cmd_i.qry_rd_a) ram_raddr = {qlvl_q, PW'(left_q - POS_W'(1))};
    else if (cmd_i.qry_rd_b) ram_raddr = {qlvl_q, PW'(qb_idx)};
    else ram_raddr = {lvl_q, PW'(rd_idx)};
  end

  sptrm_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= s_tuser_i;
      value_q <= $signed(s_tdata_i[31:0]);
      left_q  <= s_tdata_i[42:32];
      right_q <= s_tdata_i[53:43];
    end
    if (cmd_i.decode) begin
      lvl_q  <= '0;
      qlvl_q <= qlvl_d;
      res_q  <= '0;
      if (cmd_q == CMD_APPEND && tbl_full) sts_q <= STS_FULL;
      else if (cmd_q == CMD_QUERY && range_bad) sts_q <= STS_BAD_RANGE;
      else sts_q <= STS_OK;
    end
    if (cmd_i.app_step) begin
      run_q <= ram_wdata;
      if (app_more) lvl_q <= LVW'(next_lvl);
    end
    // Hold the first window while the second read is in flight
    if (cmd_i.qry_rd_b) hold_q <= rdata_s;
    if (cmd_i.qry_done) res_q <= max32(hold_q, rdata_s);
    if (cmd_i.out_load) begin
      out_max_q   <= res_q;
      out_sts_q   <= sts_q;
      out_count_q <= POS_W'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decode && cmd_q == CMD_CLEAR) count_q <= '0;
      else if (cmd_i.app_step && !app_more) count_q <= pos_new;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.app_go   = (cmd_q == CMD_APPEND) && !tbl_full;
  assign stat_o.qry_go   = (cmd_q == CMD_QUERY) && !range_bad;
  assign stat_o.app_more = app_more;
  assign stat_o.out_full = out_valid_q && !m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(M_TDATA_W - VAL_W - POS_W)'(0), out_count_q, out_max_q};
  assign m_tuser_o  = out_sts_q;

endmodule

`default_nettype wire

### rtl/sparse_table_range_max_core.sv
// Channel   Dir  Contents (lowest bit first)
// s_axis    in   tdata: value[31:0], left[42:32], right[53:43]; tuser: command[1:0]
// m_axis    out  tdata: max_value[31:0], stored_count[42:32]; tuser: status[1:0]
//
// One item at a time through a single-port-read table memory.
// Query: decode, two table reads, then compare and output.
// Append at p: min(floor(log2 p) + 1, LEVELS) levels, one level per cycle.
// Clear/rejected items: no table access. A full output register holds the item in place.
// Reset clears the count and the handshake state; the table is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sparse_table_range_max_core #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned LEVELS       = 11
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // value[31:0], left[42:32], right[53:43], zero fill above
  input  wire logic [sptrm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command[1:0]
  input  wire logic [sptrm_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // max_value[31:0], stored_count[42:32], zero fill above
  output logic      [sptrm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic      [sptrm_pkg::STS_W-1:0]     m_axis_tuser
);

  import sptrm_pkg::*;

  sptrm_cmd_t  ctrl_cmd;
  sptrm_stat_t dp_stat;

  sptrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  sptrm_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .LEVELS       (LEVELS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .cmd_i      (ctrl_cmd),
    .stat_o     (dp_stat)
  );

  `ASSERT_ALWAYS(a_cmd_onehot, clk_i, $onehot0(ctrl_cmd), "controller issued two commands at once")
  `ASSERT_RST(a_count_range, clk_i, rst_ni, m_axis_tvalid |-> int'(m_axis_tdata[42:32]) <= int'(MAX_ELEMENTS), "stored count above capacity")
  `ASSERT_RST(a_full_count, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == STS_FULL) |-> m_axis_tdata[42:32] == 11'(MAX_ELEMENTS), "full status with room left")
  `ASSERT_RST(a_err_zero, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != STS_OK) |-> m_axis_tdata[31:0] == '0, "rejected item carries a nonzero maximum")

endmodule

`default_nettype wire

### tb/sparse_table_range_max_core_tb.sv
`timescale 1ns / 1ps

module sparse_table_range_max_core_tb;
  import sptrm_pkg::*;

  localparam int unsigned CAPACITY         = 1024;
  localparam int unsigned NUM_LEVELS       = 11;
  localparam int unsigned RANDOM_ITEMS     = 620;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;

  typedef struct packed {
    logic signed [VAL_W-1:0] max_value;
    logic [STS_W-1:0]        status;
    logic [POS_W-1:0]        stored_count;
  } range_result_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] right;
    logic             typed;
    range_result_t    result;
  } query_row_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [CMD_W-1:0]     s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [STS_W-1:0]     m_axis_tuser;

  // Expectation typed into the directed table, travels alongside the item
  logic          row_typed  = 1'b0;
  range_result_t row_result = '0;

  logic          no_idle       = 1'b0;
  logic          long_hold_req = 1'b0;
  int unsigned   items_accepted = 0;
  int unsigned   sent_count     = 0;
  int unsigned   failures       = 0;

  // Shadow of the sparse table and its element count
  logic signed [VAL_W-1:0] win_max [CAPACITY*NUM_LEVELS];
  int unsigned             held_count = 0;
  range_result_t           expected_results [$];

  sparse_table_range_max_core #(
    .MAX_ELEMENTS(CAPACITY),
    .LEVELS      (NUM_LEVELS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned slot(input int unsigned pos, input int unsigned lvl);
    return (pos - 1) * NUM_LEVELS + lvl;
  endfunction

  task automatic predict_range_max(input logic [CMD_W-1:0] command,
                                   input logic signed [VAL_W-1:0] value,
                                   input logic [POS_W-1:0] left,
                                   input logic [POS_W-1:0] right,
                                   output range_result_t res);
    int unsigned p, s, h, k, len;
    logic signed [VAL_W-1:0] a, b;
    res = '0;
    res.status = STS_OK;
    if (command == CMD_APPEND) begin
      if (held_count >= CAPACITY) begin
        res.status = STS_FULL;
      end else begin
        p = held_count + 1;
        win_max[slot(p, 0)] = value;
        // fill every window that ends at the new position
        for (k = 1; k < NUM_LEVELS && (1 << k) <= p; k++) begin
          s = p - (1 << k) + 1;
          h = s + (1 << (k - 1));
          a = win_max[slot(s, k - 1)];
          b = win_max[slot(h, k - 1)];
          win_max[slot(s, k)] = (a > b) ? a : b;
        end
        held_count = p;
      end
    end else if (command == CMD_QUERY) begin
      if (left == 0 || right < left || right > held_count) begin
        res.status = STS_BAD_RANGE;
      end else begin
        len = right - left + 1;
        k = 0;
        while ((len >> (k + 1)) != 0) k++;
        if (k >= NUM_LEVELS) k = NUM_LEVELS - 1;
        s = right - (1 << k) + 1;
        a = win_max[slot(left, k)];
        b = win_max[slot(s, k)];
        res.max_value = (a > b) ? a : b;
      end
    end else if (command == CMD_CLEAR) begin
      held_count = 0;
    end
    res.stored_count = POS_W'(held_count);
  endtask

  always @(posedge clk_i) begin : scoreboard
    range_result_t predicted, seen, want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_range_max(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[42:32],
                          s_axis_tdata[53:43], predicted);
        expected_results.push_back(row_typed ? row_result : predicted);
        items_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.max_value    = m_axis_tdata[31:0];
        seen.stored_count = m_axis_tdata[42:32];
        seen.status       = m_axis_tuser;
        if (expected_results.size() == 0) begin
          $error("unexpected result: max_value %0d status %0d stored_count %0d",
                 seen.max_value, seen.status, seen.stored_count);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (seen.max_value !== want.max_value) begin
            $error("max_value: expected %0d, actual %0d", want.max_value, seen.max_value);
            failures++;
          end
          if (seen.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, seen.status);
            failures++;
          end
          if (seen.stored_count !== want.stored_count) begin
            $error("stored_count: expected %0d, actual %0d",
                   want.stored_count, seen.stored_count);
            failures++;
          end
        end
      end
    end
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : receiver
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk_i);
        long_hold_req = 1'b0;
      end
      if (no_idle) begin
        m_axis_tready = 1'b1;
        stall = 0;
      end else if (stall != 0) begin
        m_axis_tready = 1'b0;
        stall--;
      end else begin
        m_axis_tready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  function automatic query_row_t item_row(input logic [CMD_W-1:0] command,
                                          input logic [VAL_W-1:0] value,
                                          input int unsigned left,
                                          input int unsigned right,
                                          input logic typed,
                                          input logic [STS_W-1:0] status,
                                          input logic [VAL_W-1:0] max_value,
                                          input int unsigned count);
    query_row_t r;
    r.command             = command;
    r.value               = value;
    r.left                = POS_W'(left);
    r.right               = POS_W'(right);
    r.typed               = typed;
    r.result.max_value    = max_value;
    r.result.status       = status;
    r.result.stored_count = POS_W'(count);
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return VAL_W'($urandom_range(0, 15)) - 32'd8;  // small values give ties
      default: return $urandom();
    endcase
  endfunction

  function automatic query_row_t random_item(input int unsigned cnt);
    query_row_t  r;
    int unsigned pick;
    r       = '0;
    r.value = random_value();
    r.left  = POS_W'($urandom_range(0, 2047));
    r.right = POS_W'($urandom_range(0, 2047));
    pick    = $urandom_range(0, 99);
    if (pick < 48) begin
      r.command = CMD_APPEND;
    end else if (pick < 93) begin
      r.command = CMD_QUERY;
      if (cnt != 0 && $urandom_range(0, 9) < 8) begin
        r.left  = POS_W'($urandom_range(1, cnt));
        r.right = POS_W'($urandom_range(r.left, cnt));
      end else begin
        case ($urandom_range(0, 3))
          0: r.left = '0;
          1: begin
            r.left  = POS_W'($urandom_range(1, 2047));
            r.right = POS_W'($urandom_range(0, r.left - 1));
          end
          2: begin
            r.left  = POS_W'($urandom_range(1, cnt + 1));
            r.right = POS_W'($urandom_range(cnt + 1, 2047));
          end
          default: ;
        endcase
      end
    end else if (pick < 95) begin
      r.command = CMD_CLEAR;
    end else begin
      r.command = CMD_UNUSED;
    end
    return r;
  endfunction

  // Call at a falling edge; return at the falling edge after the item is taken
  task automatic send_item(input query_row_t r);
    int unsigned gap, taken;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = r.command;
    s_axis_tdata  = {2'b00, r.right, r.left, r.value};
    row_typed     = r.typed;
    row_result    = r.result;
    s_axis_tvalid = 1'b1;
    taken = items_accepted;
    do @(negedge clk_i); while (items_accepted == taken);
    case (r.command)
      CMD_APPEND: if (sent_count < CAPACITY) sent_count++;
      CMD_CLEAR:  sent_count = 0;
      default:    ;
    endcase
  endtask

  initial begin : stimulus
    query_row_t  rows [$];
    int unsigned i, guard;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rows.push_back(item_row(CMD_QUERY,  '0, 1, 1, 1, STS_BAD_RANGE, '0, 0));
    rows.push_back(item_row(CMD_APPEND, 32'h7FFF_FFFF, 0, 0, 1, STS_OK, '0, 1));
    rows.push_back(item_row(CMD_APPEND, 32'h8000_0000, 0, 0, 1, STS_OK, '0, 2));
    rows.push_back(item_row(CMD_APPEND, 32'h0000_0000, 0, 0, 1, STS_OK, '0, 3));
    rows.push_back(item_row(CMD_APPEND, 32'hFFFF_FFFF, 0, 0, 1, STS_OK, '0, 4));
    rows.push_back(item_row(CMD_APPEND, 32'h0000_0005, 0, 0, 1, STS_OK, '0, 5));
    rows.push_back(item_row(CMD_QUERY,  '0, 1, 1, 1, STS_OK, 32'h7FFF_FFFF, 5));
    rows.push_back(item_row(CMD_QUERY,  '0, 2, 2, 1, STS_OK, 32'h8000_0000, 5));
    rows.push_back(item_row(CMD_QUERY,  '0, 2, 5, 0, STS_OK, '0, 0));
    rows.push_back(item_row(CMD_QUERY,  '0, 1, 5, 0, STS_OK, '0, 0));
    rows.push_back(item_row(CMD_QUERY,  '0, 3, 4, 0, STS_OK, '0, 0));
    rows.push_back(item_row(CMD_QUERY,  '0, 0, 3, 1, STS_BAD_RANGE, '0, 5));
    rows.push_back(item_row(CMD_QUERY,  '0, 4, 3, 1, STS_BAD_RANGE, '0, 5));
    rows.push_back(item_row(CMD_QUERY,  '0, 1, 6, 1, STS_BAD_RANGE, '0, 5));
    rows.push_back(item_row(CMD_QUERY,  '0, 2047, 2047, 1, STS_BAD_RANGE, '0, 5));
    rows.push_back(item_row(CMD_UNUSED, 32'hFFFF_FFFF, 2047, 2047, 1, STS_OK, '0, 5));
    rows.push_back(item_row(CMD_QUERY,  '0, 5, 5, 1, STS_OK, 32'h0000_0005, 5));
    rows.push_back(item_row(CMD_CLEAR,  '0, 0, 0, 1, STS_OK, '0, 0));
    rows.push_back(item_row(CMD_QUERY,  '0, 1, 1, 1, STS_BAD_RANGE, '0, 0));
    rows.push_back(item_row(CMD_APPEND, 32'h8000_0000, 0, 0, 1, STS_OK, '0, 1));
    rows.push_back(item_row(CMD_APPEND, 32'h8000_0000, 0, 0, 1, STS_OK, '0, 2));
    rows.push_back(item_row(CMD_APPEND, 32'h1234_5678, 0, 0, 1, STS_OK, '0, 3));
    rows.push_back(item_row(CMD_QUERY,  '0, 1, 3, 0, STS_OK, '0, 0));
    rows.push_back(item_row(CMD_QUERY,  '0, 1, 2, 0, STS_OK, '0, 0));
    foreach (rows[j]) send_item(rows[j]);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = (i >= 150 && i < 230);
      // starve the output so the block backs up into its input
      if (i == 300) long_hold_req = 1'b1;
      if (i == 450) begin
        s_axis_tvalid = 1'b0;
        while (expected_results.size() != 0) @(negedge clk_i);
      end
      send_item(random_item(sent_count));
    end

    send_item(item_row(CMD_CLEAR, '0, 0, 0, 1, STS_OK, '0, 0));
    s_axis_tvalid = 1'b0;

    guard = 0;
    while (expected_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    // allow for a late extra result
    repeat (40) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
